// ===== design/pbpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbpa_pkg
// Shared types, constants and the axis routing function of the permuted box
// pack addresser.
// ----------------------------------------------------------------------------
package pbpa_pkg;

  localparam int DEF_MAX_EXTENT     = 1024;
  localparam int DEF_MAX_COMPONENTS = 16;

  localparam int EXT_W  = 11;
  localparam int COMP_W = 5;
  localparam int PERM_W = 3;
  localparam int SIGN_W = 3;
  localparam int CFG_W  = 11;
  localparam int CIDX_W = 3;
  localparam int VAL_W  = 64;
  localparam int IDX_W  = 34;

  localparam logic [CIDX_W-1:0] REG_EXTENT_I   = 3'd0;
  localparam logic [CIDX_W-1:0] REG_EXTENT_J   = 3'd1;
  localparam logic [CIDX_W-1:0] REG_EXTENT_K   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_COMPONENTS = 3'd3;
  localparam logic [CIDX_W-1:0] REG_AXIS_PERM  = 3'd4;
  localparam logic [CIDX_W-1:0] REG_AXIS_SIGN  = 3'd5;

  localparam logic [PERM_W-1:0] PERM_IJK = 3'd0;
  localparam logic [PERM_W-1:0] PERM_IKJ = 3'd1;
  localparam logic [PERM_W-1:0] PERM_JIK = 3'd2;
  localparam logic [PERM_W-1:0] PERM_JKI = 3'd3;
  localparam logic [PERM_W-1:0] PERM_KIJ = 3'd4;
  localparam logic [PERM_W-1:0] PERM_KJI = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL1 = 4'b0010,
    ST_MUL2 = 4'b0100,
    ST_MUL3 = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    MS_L1 = 2'd0,
    MS_L2 = 2'd1,
    MS_NC = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     capture;
    logic     step_en;
    mul_sel_t mul_sel;
    logic     load_out;
  } pbpa_cmd_t;

  // Local axis that lands on neighbour axis n under permutation code
  function automatic logic [1:0] perm_src(input logic [PERM_W-1:0] code,
                                          input logic [1:0] n);
    logic [5:0] src;
    begin
      unique case (code)
        PERM_IKJ: src = {2'd1, 2'd2, 2'd0};
        PERM_JIK: src = {2'd2, 2'd0, 2'd1};
        PERM_JKI: src = {2'd1, 2'd0, 2'd2};
        PERM_KIJ: src = {2'd0, 2'd2, 2'd1};
        PERM_KJI: src = {2'd0, 2'd1, 2'd2};
        default:  src = {2'd2, 2'd1, 2'd0};
      endcase
      unique case (n)
        2'd0:    perm_src = src[1:0];
        2'd1:    perm_src = src[3:2];
        default: perm_src = src[5:4];
      endcase
    end
  endfunction

endpackage

// ===== design/pbpa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbpa_ctrl
// Sequencer: takes one element, steps the shared multiply-add three times and
// loads the output register once it is free.
// ----------------------------------------------------------------------------
module pbpa_ctrl import pbpa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output pbpa_cmd_t cmd
);

  state_t state, state_next;
  logic   out_valid_next;
  logic   load_out;

  assign in_ready = (state == ST_IDLE);
  assign load_out = (state == ST_MUL3) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_MUL3;
      ST_MUL3: if (load_out) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.capture  = in_valid && in_ready;
    cmd.step_en  = (state == ST_MUL1) || (state == ST_MUL2);
    cmd.load_out = load_out;
    unique case (state)
      ST_MUL1: cmd.mul_sel = MS_L1;
      ST_MUL2: cmd.mul_sel = MS_L2;
      default: cmd.mul_sel = MS_NC;
    endcase
  end

  always_comb begin
    priority if (load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== design/pbpa_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbpa_dp
// Datapath: configuration registers, local counters, axis routing and the
// shared multiply-add that folds the neighbour coordinates into one index.
// ----------------------------------------------------------------------------
module pbpa_dp import pbpa_pkg::*; #(
  parameter int MAX_EXTENT     = DEF_MAX_EXTENT,
  parameter int MAX_COMPONENTS = DEF_MAX_COMPONENTS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic [VAL_W-1:0]  element_value,
  input  pbpa_cmd_t         cmd,
  output logic [VAL_W-1:0]  element_value_out,
  output logic [IDX_W-1:0]  dest_index,
  output logic              last_of_box
);

  localparam int CW  = $clog2(MAX_EXTENT);
  localparam int LW  = $clog2(MAX_EXTENT + 1);
  localparam int CCW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int NW  = $clog2(MAX_COMPONENTS + 1);

  logic [EXT_W-1:0]  extent [3];
  logic [COMP_W-1:0] components;
  logic [PERM_W-1:0] axis_perm;
  logic [SIGN_W-1:0] axis_sign;

  logic [CW-1:0]     count [3];
  logic [CCW-1:0]    count_comp;

  logic [LW-1:0]     len [3];
  logic [NW-1:0]     nc;
  logic [CW-1:0]     r_loc [3];
  logic [CW-1:0]     rel [3];
  logic [LW-1:0]     lnb [3];
  logic [1:0]        src [3];
  logic [3:0]        wrap;
  logic              last;

  logic [VAL_W-1:0]  value_q;
  logic [CW-1:0]     rel1_q;
  logic [CW-1:0]     rel2_q;
  logic [CCW-1:0]    comp_q;
  logic              last_q;
  logic [IDX_W-1:0]  acc;
  logic [IDX_W-1:0]  mul_op;
  logic [IDX_W-1:0]  add_op;
  logic [IDX_W-1:0]  prod;

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      if (extent[d] == '0) begin
        len[d] = LW'(1);
      end else if (32'(extent[d]) > MAX_EXTENT) begin
        len[d] = LW'(MAX_EXTENT);
      end else begin
        len[d] = LW'(extent[d]);
      end
      r_loc[d] = axis_sign[d] ? CW'(32'(len[d]) - 32'd1 - 32'(count[d])) : count[d];
    end
    if (components == '0) begin
      nc = NW'(1);
    end else if (32'(components) > MAX_COMPONENTS) begin
      nc = NW'(MAX_COMPONENTS);
    end else begin
      nc = NW'(components);
    end
  end

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      src[n] = perm_src(axis_perm, 2'(n));
      rel[n] = r_loc[src[n]];
      lnb[n] = len[src[n]];
    end
  end

  always_comb begin
    wrap[0] = !(32'(count_comp) + 32'd1 < 32'(nc));
    wrap[1] = !(32'(count[2]) + 32'd1 < 32'(len[2]));
    wrap[2] = !(32'(count[1]) + 32'd1 < 32'(len[1]));
    wrap[3] = !(32'(count[0]) + 32'd1 < 32'(len[0]));
    last    = &wrap;
  end

  // Configuration and counters; any write starts a new box
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < 3; d++) begin
        extent[d] <= EXT_W'(1);
        count[d]  <= '0;
      end
      components <= COMP_W'(1);
      axis_perm  <= '0;
      axis_sign  <= '0;
      count_comp <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EXTENT_I:   extent[0]  <= cfg_data;
        REG_EXTENT_J:   extent[1]  <= cfg_data;
        REG_EXTENT_K:   extent[2]  <= cfg_data;
        REG_COMPONENTS: components <= cfg_data[COMP_W-1:0];
        REG_AXIS_PERM:  axis_perm  <= cfg_data[PERM_W-1:0];
        REG_AXIS_SIGN:  axis_sign  <= cfg_data[SIGN_W-1:0];
        default: ;
      endcase
      for (int d = 0; d < 3; d++) begin
        count[d] <= '0;
      end
      count_comp <= '0;
    end else if (cmd.capture) begin
      count_comp <= wrap[0] ? '0 : count_comp + CCW'(1);
      if (wrap[0]) begin
        count[2] <= wrap[1] ? '0 : count[2] + CW'(1);
        if (wrap[1]) begin
          count[1] <= wrap[2] ? '0 : count[1] + CW'(1);
          if (wrap[2]) begin
            count[0] <= wrap[3] ? '0 : count[0] + CW'(1);
          end
        end
      end
    end
  end

  always_comb begin
    unique case (cmd.mul_sel)
      MS_L1: begin
        mul_op = IDX_W'(lnb[1]);
        add_op = IDX_W'(rel1_q);
      end
      MS_L2: begin
        mul_op = IDX_W'(lnb[2]);
        add_op = IDX_W'(rel2_q);
      end
      default: begin
        mul_op = IDX_W'(nc);
        add_op = IDX_W'(comp_q);
      end
    endcase
    prod = acc * mul_op + add_op;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      value_q <= element_value;
      acc     <= IDX_W'(rel[0]);
      rel1_q  <= rel[1];
      rel2_q  <= rel[2];
      comp_q  <= count_comp;
      last_q  <= last;
    end else if (cmd.step_en) begin
      acc <= prod;
    end
    if (cmd.load_out) begin
      element_value_out <= value_q;
      dest_index        <= prod;
      last_of_box       <= last_q;
    end
  end

endmodule

// ===== design/permuted_box_pack_addresser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// permuted_box_pack_addresser
// Streams box elements in local order and tags each with its linear index in
// the neighbour's permuted and possibly reversed order.
// ----------------------------------------------------------------------------
// Each element goes through ST_MUL1, ST_MUL2 and ST_MUL3, three passes through
// one shared multiply-add that fold the coordinates; a new element is taken
// only once the output register has been loaded.
// Reset clears the counters and loads extents 1, components 1, permutation
// and signs 0; any configuration write also restarts the box at its origin.
// ----------------------------------------------------------------------------
module permuted_box_pack_addresser import pbpa_pkg::*; #(
  parameter int MAX_EXTENT     = DEF_MAX_EXTENT,
  parameter int MAX_COMPONENTS = DEF_MAX_COMPONENTS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [VAL_W-1:0]  element_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [VAL_W-1:0]  element_value_out,
  output logic [IDX_W-1:0]  dest_index,
  output logic              last_of_box
);

  pbpa_cmd_t cmd;

  pbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  pbpa_dp #(
    .MAX_EXTENT     (MAX_EXTENT),
    .MAX_COMPONENTS (MAX_COMPONENTS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .element_value     (element_value),
    .cmd               (cmd),
    .element_value_out (element_value_out),
    .dest_index        (dest_index),
    .last_of_box       (last_of_box)
  );

endmodule

// ===== sim/pbpa_placement_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbpa_placement_checker
// Watches the configuration port and both streams of the permuted box pack
// addresser. It keeps its own copy of the registers and the box position,
// works out where each accepted element lands in the neighbour's buffer, and
// compares every returned element with the oldest placement still due.
// ----------------------------------------------------------------------------
module pbpa_placement_checker import pbpa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [VAL_W-1:0]  element_value,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [VAL_W-1:0]  element_value_out,
  input  logic [IDX_W-1:0]  dest_index,
  input  logic              last_of_box,
  output int                outstanding,
  output int                mismatches
);

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] index;
    logic             last;
  } placement_t;

  logic [EXT_W-1:0]  extent_q [3];
  logic [COMP_W-1:0] comps_q;
  logic [PERM_W-1:0] perm_q;
  logic [SIGN_W-1:0] sign_q;
  logic [9:0]        pos_q [3];
  logic [3:0]        comp_pos_q;
  placement_t        placements_due [$];

  task automatic restart_box();
    pos_q[0]   = '0;
    pos_q[1]   = '0;
    pos_q[2]   = '0;
    comp_pos_q = '0;
  endtask

  task automatic place_element(input logic [VAL_W-1:0] v);
    int          len [3];
    int          nlen [3];
    int          rel [3];
    int          nc, d, nd;
    logic [5:0]  route;
    logic [63:0] acc;
    placement_t  p;
    nc = (comps_q == 0) ? 1 :
         (int'(comps_q) > DEF_MAX_COMPONENTS) ? DEF_MAX_COMPONENTS : int'(comps_q);
    case (perm_q)
      PERM_IKJ: route = {2'd1, 2'd2, 2'd0};
      PERM_JIK: route = {2'd2, 2'd0, 2'd1};
      PERM_JKI: route = {2'd0, 2'd2, 2'd1};
      PERM_KIJ: route = {2'd1, 2'd0, 2'd2};
      PERM_KJI: route = {2'd0, 2'd1, 2'd2};
      default:  route = {2'd2, 2'd1, 2'd0};
    endcase
    for (d = 0; d < 3; d++) begin
      len[d] = (extent_q[d] == 0) ? 1 :
               (int'(extent_q[d]) > DEF_MAX_EXTENT) ? DEF_MAX_EXTENT : int'(extent_q[d]);
      nd = int'(route[2*d +: 2]);
      rel[nd]  = sign_q[d] ? (len[d] - 1 - int'(pos_q[d])) : int'(pos_q[d]);
      nlen[nd] = len[d];
    end
    acc = 64'(rel[0]);
    acc = acc * 64'(nlen[1]) + 64'(rel[1]);
    acc = acc * 64'(nlen[2]) + 64'(rel[2]);
    acc = acc * 64'(nc) + 64'(comp_pos_q);
    p.value = v;
    p.index = acc[IDX_W-1:0];
    p.last  = (comp_pos_q == nc - 1) && (pos_q[2] == len[2] - 1) &&
              (pos_q[1] == len[1] - 1) && (pos_q[0] == len[0] - 1);
    placements_due.push_back(p);
    // advance: component innermost, then k, j, i
    if (comp_pos_q + 1 < nc) begin
      comp_pos_q = comp_pos_q + 4'd1;
    end else begin
      comp_pos_q = '0;
      if (pos_q[2] + 1 < len[2]) begin
        pos_q[2] = pos_q[2] + 10'd1;
      end else begin
        pos_q[2] = '0;
        if (pos_q[1] + 1 < len[1]) begin
          pos_q[1] = pos_q[1] + 10'd1;
        end else begin
          pos_q[1] = '0;
          pos_q[0] = (pos_q[0] + 1 < len[0]) ? pos_q[0] + 10'd1 : 10'd0;
        end
      end
    end
  endtask

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    placement_t exp_p;
    if (rst) begin
      extent_q[0] = EXT_W'(1);
      extent_q[1] = EXT_W'(1);
      extent_q[2] = EXT_W'(1);
      comps_q     = COMP_W'(1);
      perm_q      = PERM_IJK;
      sign_q      = '0;
      restart_box();
      placements_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (placements_due.size() == 0) begin
          $display("%0t: transfer out with nothing due: value %h index %h last %b",
                   $time, element_value_out, dest_index, last_of_box);
          mismatches++;
        end else begin
          exp_p = placements_due.pop_front();
          if (element_value_out !== exp_p.value) begin
            $display("%0t: element_value_out expected %h actual %h",
                     $time, exp_p.value, element_value_out);
            mismatches++;
          end
          if (dest_index !== exp_p.index) begin
            $display("%0t: dest_index expected %h actual %h",
                     $time, exp_p.index, dest_index);
            mismatches++;
          end
          if (last_of_box !== exp_p.last) begin
            $display("%0t: last_of_box expected %b actual %b",
                     $time, exp_p.last, last_of_box);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_EXTENT_I:   extent_q[0] = cfg_data[EXT_W-1:0];
          REG_EXTENT_J:   extent_q[1] = cfg_data[EXT_W-1:0];
          REG_EXTENT_K:   extent_q[2] = cfg_data[EXT_W-1:0];
          REG_COMPONENTS: comps_q     = cfg_data[COMP_W-1:0];
          REG_AXIS_PERM:  perm_q      = cfg_data[PERM_W-1:0];
          REG_AXIS_SIGN:  sign_q      = cfg_data[SIGN_W-1:0];
          default: ;
        endcase
        restart_box();
      end
      if (in_valid && in_ready) begin
        place_element(element_value);
      end
    end
    outstanding <= placements_due.size();
  end

endmodule

// ===== sim/tb_permuted_box_pack_addresser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_permuted_box_pack_addresser
// Drives box elements through the permuted box pack addresser under a run of
// register settings: defaults, the largest box, out-of-range values and every
// axis routing, then random small boxes with occasional large ones. Both
// streams stall at random, and the output is held off in some phases long
// enough to back up the input. The placement checker judges every transfer.
// ----------------------------------------------------------------------------
module tb_permuted_box_pack_addresser;
  import pbpa_pkg::*;

  localparam int ITEMS       = 1600;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_OFF    = 300;
  localparam int TAIL        = 8;

  localparam logic [CIDX_W-1:0] REG_SPARE_LO  = 3'd6;
  localparam logic [CIDX_W-1:0] REG_SPARE_HI  = 3'd7;
  localparam logic [PERM_W-1:0] PERM_SPARE_HI = 3'd7;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic [VAL_W-1:0]  element_value;
  logic              out_valid;
  logic              out_ready;
  logic [VAL_W-1:0]  element_value_out;
  logic [IDX_W-1:0]  dest_index;
  logic              last_of_box;
  int                outstanding;
  int                mismatches;
  int                sent = 0;
  int                stall_cycles = 0;
  bit                calm = 1'b0;
  bit                hold_off_req = 1'b0;

  always #2 clk = ~clk;

  permuted_box_pack_addresser uut (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .element_value     (element_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .element_value_out (element_value_out),
    .dest_index        (dest_index),
    .last_of_box       (last_of_box)
  );

  pbpa_placement_checker placement_check (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .element_value     (element_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .element_value_out (element_value_out),
    .dest_index        (dest_index),
    .last_of_box       (last_of_box),
    .outstanding       (outstanding),
    .mismatches        (mismatches)
  );

  always @(posedge clk) begin
    if (stall_cycles >= STALL_LIMIT) begin
      $display("** permuted_box_pack_addresser: FAILED **");
      $finish;
    end
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : sink
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready    <= 1'b0;
        n            = HOLD_OFF;
        hold_off_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 16);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 40);
      end
      repeat (n - 1) @(negedge clk);
    end
  end

  task automatic offer(input logic [VAL_W-1:0] v);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    element_value <= v;
    do @(posedge clk); while (!in_ready);
    sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    wait (outstanding == 0);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [VAL_W-1:0] random_element();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin : stimulus
    int               phase_len;
    bit               large_box;
    logic [CFG_W-1:0] ext;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_EXTENT_I;
    cfg_data      = '0;
    in_valid      = 1'b0;
    element_value = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: a one-element box, every transfer ends it
    offer('0);
    offer('1);
    offer({32'hAAAA_AAAA, 32'hAAAA_AAAA});
    offer({32'h5555_5555, 32'h5555_5555});
    settle();

    // largest box, all axes reversed: indices start at the top of the range
    write_reg(REG_EXTENT_I, CFG_W'(1024));
    write_reg(REG_EXTENT_J, CFG_W'(1024));
    write_reg(REG_EXTENT_K, CFG_W'(1024));
    write_reg(REG_COMPONENTS, CFG_W'(DEF_MAX_COMPONENTS));
    write_reg(REG_AXIS_PERM, CFG_W'(PERM_KJI));
    write_reg(REG_AXIS_SIGN, '1);
    repeat (4) offer(random_element());
    settle();

    // out-of-range extents and components, unused routing code
    write_reg(REG_EXTENT_I, '0);
    write_reg(REG_EXTENT_J, '1);
    write_reg(REG_EXTENT_K, CFG_W'(1025));
    write_reg(REG_COMPONENTS, '0);
    write_reg(REG_AXIS_PERM, CFG_W'(PERM_SPARE_HI));
    write_reg(REG_AXIS_SIGN, CFG_W'(3'b101));
    repeat (3) offer(random_element());
    settle();

    // every routing with a small box
    write_reg(REG_EXTENT_I, CFG_W'(2));
    write_reg(REG_EXTENT_J, CFG_W'(3));
    write_reg(REG_EXTENT_K, CFG_W'(2));
    write_reg(REG_COMPONENTS, CFG_W'(2));
    for (int p = PERM_IJK; p <= PERM_KJI; p++) begin
      write_reg(REG_AXIS_PERM, CFG_W'(p));
      write_reg(REG_AXIS_SIGN, CFG_W'(p));
      repeat (2) offer(random_element());
      settle();
    end

    while (sent < ITEMS) begin
      if (sent > ITEMS * 7 / 8) calm = 1'b1;
      large_box = ($urandom_range(0, 9) == 0);
      for (int r = REG_EXTENT_I; r <= REG_EXTENT_K; r++) begin
        if ($urandom_range(0, 3) != 0) begin
          if (large_box) begin
            case ($urandom_range(0, 2))
              0:       ext = CFG_W'(1024);
              1:       ext = CFG_W'($urandom_range(1, 1024));
              default: ext = CFG_W'($urandom_range(1025, 2047));
            endcase
          end else begin
            ext = ($urandom_range(0, 7) == 0) ? '0 : CFG_W'($urandom_range(1, 3));
          end
          write_reg(CIDX_W'(r), ext);
        end
      end
      if ($urandom_range(0, 3) != 0) begin
        if (large_box) begin
          write_reg(REG_COMPONENTS, CFG_W'($urandom_range(16, 31)));
        end else begin
          write_reg(REG_COMPONENTS,
                    ($urandom_range(0, 9) == 0) ? '0 : CFG_W'($urandom_range(1, 4)));
        end
      end
      if ($urandom_range(0, 3) != 0) begin
        write_reg(REG_AXIS_PERM, CFG_W'($urandom_range(PERM_IJK, PERM_SPARE_HI)));
      end
      if ($urandom_range(0, 3) != 0) write_reg(REG_AXIS_SIGN, CFG_W'($urandom_range(0, 7)));
      if ($urandom_range(0, 7) == 0) begin
        write_reg(CIDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                  CFG_W'($urandom_range(0, 2047)));
      end
      phase_len = large_box ? $urandom_range(8, 20) : $urandom_range(20, 90);
      if (sent > ITEMS / 3 && sent < ITEMS / 2 && !large_box) begin
        hold_off_req = 1'b1;
        phase_len    = 90;
      end
      repeat (phase_len) offer(random_element());
      settle();
    end

    repeat (TAIL) @(negedge clk);
    if (mismatches == 0) begin
      $display("** permuted_box_pack_addresser: PASSED **");
    end else begin
      $display("** permuted_box_pack_addresser: FAILED **");
    end
    $finish;
  end

endmodule

// ===== permuted_box_pack_addresser.f =====
design/pbpa_pkg.sv
design/pbpa_ctrl.sv
design/pbpa_dp.sv
design/permuted_box_pack_addresser.sv
sim/pbpa_placement_checker.sv
sim/tb_permuted_box_pack_addresser.sv
